/* rtl/vlid_pkg.sv */
// Shared types, field positions and a helper function of the variable-length integer decoder.
`default_nettype none

package vlid_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned CountW   = 3;
  localparam int unsigned HdrBitsW = 2;
  localparam int unsigned ContW    = 6;

  // Header layout.
  localparam int unsigned HdrSignBit = 2;
  localparam int unsigned HdrCntLsb  = 3;
  localparam int unsigned HdrCntMsb  = 5;

  localparam logic [CountW-1:0] CntOne = CountW'(1);

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [CountW-1:0]        byte_count;
  } vlid_result_t;

  // Places the six payload bits of continuation byte k at bit 2 + 6*(k-1).
  // Positions at or beyond the word width contribute nothing.
  function automatic logic [ValueW-1:0] cont_bits(input logic [CountW-1:0] k,
                                                  input logic [ContW-1:0] payload);
    logic [ValueW-1:0] w;
    logic [ValueW-1:0] r;
    w = {{(ValueW-ContW){1'b0}}, payload};
    case (k)
      3'd1:    r = w << 2;
      3'd2:    r = w << 8;
      3'd3:    r = w << 14;
      3'd4:    r = w << 20;
      3'd5:    r = w << 26;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/vlid_byte_if.sv */
// Valid/ready channel that carries one byte of the encoded stream per word.
`default_nettype none

interface vlid_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

/* rtl/vlid_result_if.sv */
// Valid/ready channel that carries one decoded integer and its byte count per word.
`default_nettype none

interface vlid_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [2:0]         byte_count;

  modport source (output valid, output value, output byte_count, input ready);
  modport sink   (input valid, input value, input byte_count, output ready);
endinterface

`default_nettype wire

/* rtl/vlid_decode.sv */
// Input byte register and the decode state that gathers one integer from its bytes.
`default_nettype none

module vlid_decode (
  input  wire logic           clk,
  input  wire logic           rst,
  vlid_byte_if.sink           stream,
  output logic                res_valid,
  output vlid_pkg::vlid_result_t res_data,
  input  wire logic           res_room
);
  import vlid_pkg::*;

  logic [ByteW-1:0]  byte_reg;
  logic              byte_valid;

  logic [ValueW-1:0] accumulator, accumulator_next;
  logic [CountW-1:0] bytes_left, bytes_left_next;
  logic [CountW-1:0] bytes_seen, bytes_seen_next;
  logic              sign_flag, sign_flag_next;
  logic [CountW-1:0] total_count, total_count_next;

  logic              fire;
  logic              done;
  logic [CountW-1:0] hdr_cnt;

  assign fire         = byte_valid && res_room;
  assign stream.ready = !byte_valid || res_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (stream.ready) begin
      byte_valid <= stream.valid;
    end
    if (stream.ready && stream.valid) begin
      byte_reg <= stream.in_byte;
    end
  end

  always_comb begin
    hdr_cnt = byte_reg[HdrCntMsb:HdrCntLsb];
    if (hdr_cnt == '0) begin
      hdr_cnt = CntOne;
    end
    if (bytes_left == '0) begin
      accumulator_next = {{(ValueW-HdrBitsW){1'b0}}, byte_reg[HdrBitsW-1:0]};
      sign_flag_next   = byte_reg[HdrSignBit];
      total_count_next = hdr_cnt;
      bytes_seen_next  = CntOne;
      bytes_left_next  = hdr_cnt - CntOne;
      done             = (hdr_cnt == CntOne);
    end else begin
      accumulator_next = accumulator | cont_bits(bytes_seen, byte_reg[ContW-1:0]);
      sign_flag_next   = sign_flag;
      total_count_next = total_count;
      bytes_seen_next  = bytes_seen + CntOne;
      bytes_left_next  = bytes_left - CntOne;
      done             = (bytes_left == CntOne);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      bytes_left  <= '0;
      bytes_seen  <= '0;
      sign_flag   <= 1'b0;
      total_count <= '0;
    end else if (fire) begin
      accumulator <= accumulator_next;
      bytes_left  <= bytes_left_next;
      bytes_seen  <= bytes_seen_next;
      sign_flag   <= sign_flag_next;
      total_count <= total_count_next;
    end
  end

  assign res_valid           = fire && done;
  assign res_data.value      = sign_flag_next ? $signed(-accumulator_next)
                                              : $signed(accumulator_next);
  assign res_data.byte_count = total_count_next;

endmodule

`default_nettype wire

/* rtl/vlid_out_buf.sv */
// Two-entry result buffer that decouples the decoder from a stalling receiver.
`default_nettype none

module vlid_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  vlid_pkg::vlid_result_t push_data,
  output logic                   room,
  vlid_result_if.source          result
);
  import vlid_pkg::*;

  vlid_result_t slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         pop;

  assign pop               = result.valid && result.ready;
  assign room              = (count != 2'd2);
  assign result.valid      = (count != 2'd0);
  assign result.value      = slot[rd_ptr].value;
  assign result.byte_count = slot[rd_ptr].byte_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/varlen_int_stream_decoder.sv */
// Top level of the byte-serial decoder for variable-length signed integers.
//
// Usage: the stream channel delivers one byte of the encoded stream per word.
// The first byte of an integer is a header: bits 1:0 are value bits 1:0, bit 2
// is the sign and bits 5:3 the total byte count (a count of zero means one).
// Each continuation byte adds its low six bits above those already gathered.
// After the last byte, the result channel delivers one word with the value,
// negated when the sign is set and wrapped to 32 bits, and the byte count.
// Flow: a byte is accepted into the input register and decoded from there; the
// edge that ends a decode cycle in which the result buffer has a free entry
// writes the buffer, and the result word is valid from that edge on.
// Throughput: one byte per cycle while the result buffer has room, set by
// the single decode step between input register and two-entry result buffer.
// Reset: rst is synchronous; it empties the input register and the result
// buffer and leaves the decoder expecting a header byte.
// Stall: when the receiver holds ready low, up to two results are held in the
// buffer; once it is full the decoder holds its input byte, and stream ready
// stays low for as long as the input register holds a byte that cannot move.
`default_nettype none

module varlen_int_stream_decoder (
  input  wire logic     clk,
  input  wire logic     rst,
  vlid_byte_if.sink     stream,
  vlid_result_if.source result
);
  import vlid_pkg::*;

  logic         res_valid;
  vlid_result_t res_data;
  logic         res_room;

  // Input register and decode state.
  vlid_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_room  (res_room)
  );

  // Result buffer toward the receiver.
  vlid_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_data),
    .room      (res_room),
    .result    (result)
  );

  // The decoder only finishes an integer when the buffer has a free entry.
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_room)
    else $error("result pushed into a full buffer");

  // A delivered integer always occupied at least one byte.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.byte_count != '0))
    else $error("result with zero byte count");

  // Reset leaves nothing in flight on either side.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result.valid && !res_valid))
    else $error("result pending after reset");

  // With a free buffer entry the decoder never stalls the byte stream.
  a_ready_on_room: assert property (@(posedge clk) disable iff (rst)
    res_room |-> stream.ready)
    else $error("stream stalled while the buffer had room");

endmodule

`default_nettype wire

/* dv/tb_varlen_int_stream_decoder.sv */
// Self-checking testbench of the variable-length integer stream decoder.
`timescale 1ns / 1ps
`default_nettype none

module tb_varlen_int_stream_decoder;
  import vlid_pkg::*;

  // Mirror of the decoder: it consumes the same bytes as the block and keeps the
  // integers that the block must deliver, oldest first.
  class int_decode_board;
    logic [ValueW-1:0] gathered;
    logic [CountW-1:0] to_go;
    logic [CountW-1:0] taken;
    logic [CountW-1:0] length;
    logic              negative;
    vlid_result_t      owed_ints[$];
    int unsigned       errors;

    function new();
      gathered = '0;
      to_go    = '0;
      taken    = '0;
      length   = '0;
      negative = 1'b0;
      errors   = 0;
    endfunction

    // Advances the mirror by one accepted byte and queues the integer it completes.
    function void take_byte(input logic [ByteW-1:0] b);
      logic [CountW-1:0] cnt;
      int                pos;
      bit                done;
      vlid_result_t      r;
      done = 1'b0;
      if (to_go == 0) begin
        cnt = b[HdrCntMsb:HdrCntLsb];
        if (cnt == 0) begin
          cnt = CntOne;
        end
        negative = b[HdrSignBit];
        length   = cnt;
        gathered = {{(ValueW-HdrBitsW){1'b0}}, b[HdrBitsW-1:0]};
        taken    = CntOne;
        if (cnt == CntOne) begin
          done = 1'b1;
        end else begin
          to_go = cnt - CntOne;
        end
      end else begin
        pos = HdrBitsW + ContW * (int'(taken) - 1);
        if (pos < ValueW) begin
          gathered = gathered | ({{(ValueW-ContW){1'b0}}, b[ContW-1:0]} << pos);
        end
        taken = taken + CntOne;
        to_go = to_go - CntOne;
        done  = (to_go == 0);
      end
      if (done) begin
        r.value      = negative ? ValueW'(0) - gathered : gathered;
        r.byte_count = length;
        owed_ints.push_back(r);
        to_go = '0;
      end
    endfunction

    // Compares one delivered integer with the oldest one owed.
    function void match_int(input logic [ValueW-1:0] value,
                            input logic [CountW-1:0] byte_count);
      vlid_result_t want;
      if (owed_ints.size() == 0) begin
        $display("%0t: unexpected word, value %0d count %0d", $time,
                 $signed(value), byte_count);
        errors++;
      end else begin
        want = owed_ints.pop_front();
        if (want.value !== value) begin
          $display("%0t: value expected %0d actual %0d", $time,
                   $signed(want.value), $signed(value));
          errors++;
        end
        if (want.byte_count !== byte_count) begin
          $display("%0t: byte_count expected %0d actual %0d", $time,
                   want.byte_count, byte_count);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  vlid_byte_if   bytes_ch ();
  vlid_result_if ints_ch ();

  varlen_int_stream_decoder i_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (bytes_ch),
    .result (ints_ch)
  );

  int_decode_board board = new();

  // Set for the closing stretch of the run, where neither side idles.
  bit calm = 1'b0;

  // Directed words: zero counts with the ignored top bits set and clear, a
  // negative zero, an explicit count of one, seven-byte integers whose last
  // byte falls outside the word (positive and negated), the most negative
  // value that negates to itself, and a two-byte integer whose continuation
  // carries junk in its top bits.
  logic [ByteW-1:0] directed_words [] = '{
    8'h00, 8'hC7, 8'h04, 8'h0B,
    8'h3B, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h3F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h34, 8'h00, 8'h00, 8'h00, 8'h00, 8'h20,
    8'h12, 8'hC1
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Puts one byte on the stream channel and returns at the edge that takes it.
  // The ready seen right after the edge is the value the edge itself sampled.
  task automatic put_byte(input logic [ByteW-1:0] b);
    bytes_ch.valid   <= 1'b1;
    bytes_ch.in_byte <= b;
    @(posedge clk);
    while (!bytes_ch.ready) @(posedge clk);
  endtask

  // Random sender gap after a word, so that gaps land between any two bytes of
  // an integer as well as between integers.
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      bytes_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stimulus: the directed words, then whole integers with random headers and
  // random continuation bytes. The header count decides how many continuation
  // bytes follow, so the framing always stays aligned with the block.
  initial begin
    logic [ByteW-1:0] hdr;
    int unsigned      cnt;
    int unsigned      sent;
    bit               drained;
    bytes_ch.valid   <= 1'b0;
    bytes_ch.in_byte <= '0;
    sent    = 0;
    drained = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);

    foreach (directed_words[i]) begin
      put_byte(directed_words[i]);
      sender_gap();
      sent++;
    end

    while (sent < 600) begin
      if (sent >= 500) begin
        calm = 1'b1;
      end
      // Once, in the middle of the run, let the block drain completely before
      // the next integer starts.
      if (!drained && sent >= 300) begin
        drained = 1'b1;
        bytes_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.owed_ints.size() != 0) @(posedge clk);
      end
      hdr = ByteW'($urandom_range(0, 255));
      cnt = (hdr[HdrCntMsb:HdrCntLsb] == 0) ? 1 : hdr[HdrCntMsb:HdrCntLsb];
      put_byte(hdr);
      sender_gap();
      sent++;
      for (int k = 1; k < cnt; k++) begin
        put_byte(ByteW'($urandom_range(0, 255)));
        sender_gap();
        sent++;
      end
    end
    bytes_ch.valid <= 1'b0;

    // Wait for the last integers, then wait on to catch any stray word from the
    // two-stage pipeline.
    while (board.owed_ints.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.owed_ints.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: ready mostly high, dropped low in random bursts outside the closing stretch.
  initial begin
    ints_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        ints_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        ints_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Both channels are watched at the same edge. The stream side goes first so
  // that an integer completed by a byte is owed before any word is checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (bytes_ch.valid && bytes_ch.ready) begin
        board.take_byte(bytes_ch.in_byte);
      end
      if (ints_ch.valid && ints_ch.ready) begin
        board.match_int(ints_ch.value, ints_ch.byte_count);
      end
    end
  end

  // Guard against a hung handshake; far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
